// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, also checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/itt_pkg.sv =====
`timescale 1ns / 1ps

package itt_pkg;

  // List nesting depth counter width
  localparam int NEST_DEPTH_BITS = 8;

  // Transaction queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Tokenizer mode
  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_RIGHT   = 3'd1,
    MODE_NAME    = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_LIST    = 3'd4
  } mode_t;

  // Result kinds
  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  // Token kinds for a close
  localparam logic [1:0] TK_IDENT   = 2'd0;
  localparam logic [1:0] TK_SECTION = 2'd1;
  localparam logic [1:0] TK_VALUE   = 2'd2;

  // Special characters
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_RBRK = 8'h5D;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] token_kind;
    logic       last;
  } out_item_t;

  // One queue entry: all results of one input byte
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

// ===== rtl/itt_front.sv =====
`timescale 1ns / 1ps

module itt_front import itt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output q_push_t  push
);

  localparam logic [NEST_DEPTH_BITS-1:0] NEST_MAX = '1;
  localparam logic [NEST_DEPTH_BITS-1:0] NEST_ONE = NEST_DEPTH_BITS'(1);

  mode_t                      mode_r, mode_nxt;
  logic [NEST_DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic                       pend_r, pend_nxt;

  logic       has0, has1, at_start, fire;
  logic [7:0] c;
  out_item_t  r0, rclose;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign c        = in_data.text_byte;

  // Classify the byte and work out the results and next state
  always_comb begin
    has0      = 1'b0;
    r0        = '0;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    pend_nxt  = pend_r;
    at_start  = (mode_r != MODE_RIGHT) && (mode_r != MODE_NAME) &&
                (mode_r != MODE_COMMENT) && (mode_r != MODE_LIST);

    priority if (c == CH_EQ && at_start) begin
      has0          = 1'b1;
      r0.kind       = KIND_CLOSE;
      r0.token_kind = TK_IDENT;
      pend_nxt      = 1'b0;
      mode_nxt      = MODE_RIGHT;
    end else if (c == CH_SEMI && at_start) begin
      mode_nxt = MODE_COMMENT;
    end else if (c == CH_LBRK && at_start) begin
      mode_nxt = MODE_NAME;
    end else if (c == CH_RBRK && mode_r == MODE_NAME) begin
      has0          = 1'b1;
      r0.kind       = KIND_CLOSE;
      r0.token_kind = TK_SECTION;
      pend_nxt      = 1'b0;
      mode_nxt      = MODE_START;
    end else if (c == CH_LPAR && mode_r == MODE_RIGHT) begin
      has0        = 1'b1;
      r0.kind     = KIND_APPEND;
      r0.out_byte = c;
      pend_nxt    = 1'b1;
      depth_nxt   = NEST_ONE;
      mode_nxt    = MODE_LIST;
    end else if (c == CH_RPAR && mode_r == MODE_LIST && depth_r == NEST_ONE) begin
      // closing paren of the outer list: append, then the close follows
      has0        = 1'b1;
      r0.kind     = KIND_APPEND;
      r0.out_byte = c;
      pend_nxt    = 1'b1;
      mode_nxt    = MODE_START;
    end else if (c == CH_LPAR && mode_r == MODE_LIST) begin
      has0        = 1'b1;
      r0.kind     = KIND_APPEND;
      r0.out_byte = c;
      pend_nxt    = 1'b1;
      if (depth_r != NEST_MAX) begin
        depth_nxt = depth_r + NEST_ONE;
      end
    end else if (c == CH_RPAR && mode_r == MODE_LIST) begin
      has0        = 1'b1;
      r0.kind     = KIND_APPEND;
      r0.out_byte = c;
      pend_nxt    = 1'b1;
      if (depth_r != '0) begin
        depth_nxt = depth_r - NEST_ONE;
      end
    end else if ((c == CH_NL || c == CH_SEMI) && mode_r == MODE_RIGHT) begin
      has0          = 1'b1;
      r0.kind       = KIND_CLOSE;
      r0.token_kind = TK_VALUE;
      pend_nxt      = 1'b0;
      mode_nxt      = (c == CH_SEMI) ? MODE_COMMENT : MODE_START;
    end else if (c == CH_NL && mode_r == MODE_COMMENT) begin
      has0     = 1'b1;
      r0.kind  = KIND_DISCARD;
      pend_nxt = 1'b0;
      mode_nxt = MODE_START;
    end else if (mode_r == MODE_COMMENT) begin
      // comment text is swallowed
    end else if (!is_space(c)) begin
      has0        = 1'b1;
      r0.kind     = KIND_APPEND;
      r0.out_byte = c;
      pend_nxt    = 1'b1;
    end

    // Second result: outer list close, or value flush at end of text
    rclose            = '0;
    rclose.kind       = KIND_CLOSE;
    rclose.token_kind = TK_VALUE;
    rclose.last       = 1'b1;
    has1 = (c == CH_RPAR && mode_r == MODE_LIST && depth_r == NEST_ONE) ||
           (in_data.end_of_text && mode_nxt == MODE_RIGHT && pend_nxt);
    if (has1) begin
      pend_nxt = 1'b0;
    end
  end

  // Pack the results into one queue entry
  always_comb begin
    push.valid     = fire && (has0 || has1);
    push.entry.two = has0 && has1;
    push.entry.r1  = rclose;
    if (has0) begin
      push.entry.r0      = r0;
      push.entry.r0.last = !has1;
    end else begin
      push.entry.r0 = rclose;
    end
  end

  // Tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      depth_r <= '0;
      pend_r  <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ===== rtl/itt_queue.sv =====
`timescale 1ns / 1ps

module itt_queue import itt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    full,
  output q_head_t head,
  input  logic    pop
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rd_r];
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = push.valid ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push.valid && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_r] <= push.entry;
    end
  end

endmodule

// ===== rtl/itt_back.sv =====
`timescale 1ns / 1ps

module itt_back import itt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_entry_t cur_r, cur_nxt;
  logic     busy_r, busy_nxt;
  logic     sel_r, sel_nxt;
  logic     out_fire, done;

  assign out_valid = busy_r;
  assign out_data  = sel_r ? cur_r.r1 : cur_r.r0;
  assign out_fire  = busy_r && out_ready;
  assign done      = out_fire && (sel_r || !cur_r.two);
  assign pop       = head.valid && (!busy_r || done);

  // Step through the results of the current entry, refill from the queue
  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    if (pop) begin
      cur_nxt  = head.entry;
      busy_nxt = 1'b1;
      sel_nxt  = 1'b0;
    end else if (done) begin
      busy_nxt = 1'b0;
      sel_nxt  = 1'b0;
    end else if (out_fire) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

// ===== rtl/ini_text_tokenizer_top.sv =====
`timescale 1ns / 1ps
// Path: a byte's first result passes a queue entry and the emitter's register.
// Throughput: one byte per cycle while the queue has room; a byte with two
// results holds the output until both are taken, which the 4-entry queue
// between classifier and emitter absorbs. Bytes with no result (whitespace,
// comment text) emit nothing. Reset: synchronous, active low; mode to start,
// depth and pending flag to zero, queue emptied, no result pending.

module ini_text_tokenizer_top import itt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  itt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  itt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  itt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/itt_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itt_checker import itt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic stall;
  logic fields_zero;
  logic lone_kind;

  assign stall = out_valid && !out_ready;

  // Field not used by the result kind reads zero
  assign fields_zero = (out_data.kind == KIND_APPEND) ? (out_data.token_kind == TK_IDENT) :
                                                        (out_data.out_byte == 8'd0);

  // Discard, identifier close and section close
  assign lone_kind = out_valid && (out_data.kind == KIND_DISCARD ||
                     (out_data.kind == KIND_CLOSE && out_data.token_kind != TK_VALUE));

  // Stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(out_data))

  // Unused payload fields are zero
  `ASSERT_IMPL(a_zero_fields, clk, rst_n, out_valid, fields_zero)

  // Discard and identifier or section close always stand alone for their byte
  `ASSERT_IMPL(a_single_last, clk, rst_n, lone_kind, out_data.last)

  // Reset empties the output
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid && in_ready)

endmodule

bind ini_text_tokenizer_top itt_checker u_itt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
